[rtl/ili_pkg.sv]
`default_nettype none

package ili_pkg;

   // Default number of entries in the list store
   localparam int CAPACITY_DEF = 64;

   // Fixed field widths
   localparam int MODE_W  = 3;
   localparam int POS_W   = 7;
   localparam int VALUE_W = 32;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_HEAD   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TAIL   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_AT     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_ISSUE,
      ST_RD_WAIT,
      ST_SHIFT_UP,
      ST_PUT,
      ST_SHIFT_DOWN,
      ST_RESP
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic read;
      logic capture;
      logic shift_up;
      logic shift_down;
      logic put;
      logic len_inc;
      logic len_dec;
      logic set_ok;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic ins_ok;
      logic del_ok;
      logic rd_ok;
      logic up_more;
      logic down_more;
   } status_type;

endpackage

`default_nettype wire

[rtl/ili_ram.sv]
`default_nettype none

module ili_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/ili_ctrl.sv]
`default_nettype none

module ili_ctrl
   import ili_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic [MODE_W-1:0] req_mode,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire status_type        status,
   output      cmd_type           cmd
);

   state_type state_ff;
   state_type state_in;

   // Hold the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decide next state and issue datapath commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_mode)
                  MODE_READ:   state_in = status.rd_ok ? ST_RD_ISSUE : ST_RESP;
                  MODE_HEAD,
                  MODE_TAIL,
                  MODE_AT:     state_in = status.ins_ok ? ST_SHIFT_UP : ST_RESP;
                  MODE_DELETE: state_in = status.del_ok ? ST_SHIFT_DOWN : ST_RESP;
                  default:     state_in = ST_RESP;
               endcase
            end
         end
         ST_RD_ISSUE: begin
            cmd.read = 1'b1;
            state_in = ST_RD_WAIT;
         end
         ST_RD_WAIT: begin
            cmd.capture = 1'b1;
            state_in    = ST_RESP;
         end
         ST_SHIFT_UP: begin
            // Move entries up one place, last one first
            if (status.up_more) begin
               cmd.shift_up = 1'b1;
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            cmd.put     = 1'b1;
            cmd.len_inc = 1'b1;
            cmd.set_ok  = 1'b1;
            state_in    = ST_RESP;
         end
         ST_SHIFT_DOWN: begin
            // Move entries down one place, first one first
            if (status.down_more) begin
               cmd.shift_down = 1'b1;
            end else begin
               cmd.len_dec = 1'b1;
               cmd.set_ok  = 1'b1;
               state_in    = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A result only follows work on an accepted item
   a_resp_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && $past(state_ff) != ST_RESP) |->
         ($past(state_ff) == ST_IDLE || $past(state_ff) == ST_RD_WAIT ||
          $past(state_ff) == ST_PUT || $past(state_ff) == ST_SHIFT_DOWN))
      else $error("result state entered from an unexpected state");

   // No new item is taken while a result is outstanding
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while a result is pending");

   // An insert always ends with a write of the new value
   a_put_after_up: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT_UP && !status.up_more) |=> cmd.put)
      else $error("insert shift did not end in a put");

endmodule

`default_nettype wire

[rtl/ili_dp.sv]
`default_nettype none

module ili_dp
   import ili_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   output      status_type                status,
   input  wire logic [MODE_W-1:0]         req_mode,
   input  wire logic [POS_W-1:0]          req_position,
   input  wire logic signed [VALUE_W-1:0] req_value,
   output      logic signed [VALUE_W-1:0] rsp_read_value,
   output      logic                      rsp_ok,
   output      logic [POS_W-1:0]          rsp_length
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int XW = LW + POS_W;

   logic [LW-1:0]      len_ff, len_in;
   logic [LW-1:0]      idx_ff, idx_in;
   logic [LW-1:0]      pos_ff, pos_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      pend_addr_ff, pend_addr_in;
   logic [VALUE_W-1:0] res_value_ff, res_value_in;
   logic               res_ok_ff, res_ok_in;

   logic [XW-1:0]      pos_x, len_x, pos_eff_x, pos1_x, len_wide;
   logic               full;
   logic [LW-1:0]      idx_m1;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [VALUE_W-1:0] ram_wdata, ram_rdata;

   // Check the request against the current length
   always_comb begin
      pos_x  = XW'(req_position);
      len_x  = XW'(len_ff);
      pos1_x = pos_x + XW'(1);
      full   = (len_ff == LW'(CAPACITY));
      case (req_mode)
         MODE_HEAD: pos_eff_x = '0;
         MODE_TAIL: pos_eff_x = len_x;
         default:   pos_eff_x = pos_x;
      endcase
      status.ins_ok    = !full && (pos_eff_x <= len_x);
      status.del_ok    = pos_x < len_x;
      status.rd_ok     = pos_x < len_x;
      status.up_more   = idx_ff > pos_ff;
      status.down_more = idx_ff < len_ff;
   end

   assign idx_m1 = idx_ff - LW'(1);

   // Next values of the datapath registers
   always_comb begin
      len_in       = len_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      value_in     = value_ff;
      pend_in      = cmd.shift_up | cmd.shift_down;
      pend_addr_in = pend_addr_ff;
      res_value_in = res_value_ff;
      res_ok_in    = res_ok_ff;
      if (cmd.accept) begin
         pos_in       = pos_eff_x[LW-1:0];
         idx_in       = (req_mode == MODE_DELETE) ? pos1_x[LW-1:0] : len_ff;
         value_in     = req_value;
         res_value_in = '1;
         res_ok_in    = 1'b0;
      end
      if (cmd.shift_up) begin
         pend_addr_in = idx_ff[AW-1:0];
         idx_in       = idx_m1;
      end
      if (cmd.shift_down) begin
         pend_addr_in = idx_m1[AW-1:0];
         idx_in       = idx_ff + LW'(1);
      end
      if (cmd.capture) begin
         res_value_in = ram_rdata;
         res_ok_in    = 1'b1;
      end
      if (cmd.set_ok) begin
         res_ok_in = 1'b1;
      end
      if (cmd.len_inc) begin
         len_in = len_ff + LW'(1);
      end
      if (cmd.len_dec) begin
         len_in = len_ff - LW'(1);
      end
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         len_ff  <= len_in;
         pend_ff <= pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      value_ff     <= value_in;
      pend_addr_ff <= pend_addr_in;
      res_value_ff <= res_value_in;
      res_ok_ff    <= res_ok_in;
   end

   // Memory port selection: a pending shift write or the new value
   always_comb begin
      ram_we    = pend_ff | cmd.put;
      ram_waddr = cmd.put ? pos_ff[AW-1:0] : pend_addr_ff;
      ram_wdata = cmd.put ? value_ff : ram_rdata;
      if (cmd.read) begin
         ram_raddr = pos_ff[AW-1:0];
      end else if (cmd.shift_up) begin
         ram_raddr = idx_m1[AW-1:0];
      end else begin
         ram_raddr = idx_ff[AW-1:0];
      end
   end

   ili_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Drive the result fields
   assign len_wide       = XW'(len_ff);
   assign rsp_read_value = res_value_ff;
   assign rsp_ok         = res_ok_ff;
   assign rsp_length     = len_wide[POS_W-1:0];

   // The new value never collides with a pending shift write
   a_put_no_pend: assert property (@(posedge clock) disable iff (reset)
      cmd.put |-> !pend_ff)
      else $error("put collides with a pending shift write");

   // Length stays within the store
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(CAPACITY))
      else $error("list length beyond capacity");

   // A completed insert grows the list by one
   a_len_inc: assert property (@(posedge clock) disable iff (reset)
      cmd.len_inc |=> (len_ff == $past(len_ff) + LW'(1)))
      else $error("insert did not grow the list by one");

endmodule

`default_nettype wire

[rtl/indexed_list_insert_delete_top.sv]
`default_nettype none

// Channel   Ports                                       Direction
// request   req_valid/req_ready, req_mode,              in
//           req_position, req_value
// response  rsp_valid/rsp_ready, rsp_read_value,        out
//           rsp_ok, rsp_length
//
// One item is worked at a time: a read, an insert, a delete or a refused
// item each runs to its result before the next accept. Shifts move one
// entry per cycle through the list memory (one read and one write port).
// Reset clears the length and the controller; the memory is not cleared.
// A stalled result holds until taken; no new item is accepted meanwhile.

module indexed_list_insert_delete_top
   import ili_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire logic [MODE_W-1:0]         req_mode,
   input  wire logic [POS_W-1:0]          req_position,
   input  wire logic signed [VALUE_W-1:0] req_value,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   output      logic signed [VALUE_W-1:0] rsp_read_value,
   output      logic                      rsp_ok,
   output      logic [POS_W-1:0]          rsp_length
);

   cmd_type    cmd;
   status_type status;

   ili_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ili_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_mode       (req_mode),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_read_value (rsp_read_value),
      .rsp_ok         (rsp_ok),
      .rsp_length     (rsp_length)
   );

endmodule

`default_nettype wire
